@@ rtl/dbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_pkg
// Shared widths, constants, register indexes and types for the detection box
// decoder.
// ----------------------------------------------------------------------------
package dbd_pkg;

  // Field widths
  localparam int FEAT_W   = 16;  // Q4.12 feature value
  localparam int SIZE_W   = 13;  // image size register
  localparam int THR_W    = 15;  // confidence threshold
  localparam int NCLS_W   = 7;   // class count / feature counter
  localparam int CLS_W    = 4;   // class index
  localparam int COORD_W  = 12;  // corner coordinate
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Fixed-point and scoring constants
  localparam int FRAC_BITS          = 12;
  localparam int MAX_SCORED_CLASSES = 10;
  localparam int CLASS_LIMIT        = 80;
  localparam int MAX_IMAGE_SIZE     = 4096;
  localparam int BOX_FEATURES       = 4;

  // Corner arithmetic widths: 2*c +/- s, then times the size
  localparam int NUM_W  = FEAT_W + 2;
  localparam int PROD_W = NUM_W + SIZE_W + 1;
  localparam int QUO_W  = PROD_W - 1 - (FRAC_BITS + 1);

  // Register reset values
  localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RST    = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RST   = SIZE_W'(640);
  localparam logic [THR_W-1:0]  CONF_THRESHOLD_RST = THR_W'(2048);
  localparam logic [NCLS_W-1:0] NUM_CLASSES_RST    = NCLS_W'(10);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH    = 2'd0,
    CFG_IMAGE_HEIGHT   = 2'd1,
    CFG_CONF_THRESHOLD = 2'd2,
    CFG_NUM_CLASSES    = 2'd3
  } cfg_idx_e;

  // One finished proposal, as handed to the corner pipeline
  typedef struct packed {
    logic signed [FEAT_W-1:0] center_x;
    logic signed [FEAT_W-1:0] center_y;
    logic signed [FEAT_W-1:0] box_width;
    logic signed [FEAT_W-1:0] box_height;
    logic signed [FEAT_W-1:0] score;
    logic        [CLS_W-1:0]  class_index;
  } prop_t;

  // Stage load enables for the corner lanes
  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } pipe_ctrl_t;

  // Frame size limited to the largest supported frame
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
    if (size > SIZE_W'(MAX_IMAGE_SIZE)) begin
      return SIZE_W'(MAX_IMAGE_SIZE);
    end
    return size;
  endfunction

endpackage

@@ rtl/dbd_accum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_accum
// Collects the features of one proposal: holds the box values, tracks the
// best class score and flags the last feature and whether it passes.
// ----------------------------------------------------------------------------
module dbd_accum (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  logic signed [dbd_pkg::FEAT_W-1:0] feature_value_i,
  input  logic        [dbd_pkg::NCLS_W-1:0] num_classes_i,
  input  logic        [dbd_pkg::THR_W-1:0]  conf_threshold_i,
  output logic                              is_last_o,
  output logic                              emit_o,
  output dbd_pkg::prop_t                    prop_o
);

  logic        [dbd_pkg::NCLS_W-1:0] count_q, count_d;
  logic signed [dbd_pkg::FEAT_W-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [dbd_pkg::FEAT_W-1:0] bw_q, bw_d, bh_q, bh_d;
  logic signed [dbd_pkg::FEAT_W-1:0] best_q, best_d;
  logic        [dbd_pkg::CLS_W-1:0]  cls_q, cls_d;
  logic        [dbd_pkg::NCLS_W-1:0] ncls_eff;
  logic        [dbd_pkg::NCLS_W-1:0] last_pos;
  logic        [dbd_pkg::NCLS_W-1:0] class_pos;

  // Effective class count and position of the last feature
  always_comb begin
    ncls_eff = num_classes_i;
    if (num_classes_i == '0) begin
      ncls_eff = dbd_pkg::NCLS_W'(1);
    end else if (num_classes_i > dbd_pkg::NCLS_W'(dbd_pkg::CLASS_LIMIT)) begin
      ncls_eff = dbd_pkg::NCLS_W'(dbd_pkg::CLASS_LIMIT);
    end
    last_pos = ncls_eff + dbd_pkg::NCLS_W'(dbd_pkg::BOX_FEATURES - 1);
  end

  assign is_last_o = (count_q >= last_pos);
  assign class_pos = count_q - dbd_pkg::NCLS_W'(dbd_pkg::BOX_FEATURES);

  // Next hold values with the current word folded in
  always_comb begin
    cx_d   = cx_q;
    cy_d   = cy_q;
    bw_d   = bw_q;
    bh_d   = bh_q;
    best_d = best_q;
    cls_d  = cls_q;
    if (count_q == dbd_pkg::NCLS_W'(0)) begin
      cx_d = feature_value_i;
    end else if (count_q == dbd_pkg::NCLS_W'(1)) begin
      cy_d = feature_value_i;
    end else if (count_q == dbd_pkg::NCLS_W'(2)) begin
      bw_d = feature_value_i;
    end else if (count_q == dbd_pkg::NCLS_W'(3)) begin
      bh_d = feature_value_i;
    end else if (class_pos == '0) begin
      best_d = feature_value_i;
      cls_d  = '0;
    end else if ((class_pos < dbd_pkg::NCLS_W'(dbd_pkg::MAX_SCORED_CLASSES)) &&
                 (feature_value_i > best_q)) begin
      // strictly greater only: ties stay with the lower class
      best_d = feature_value_i;
      cls_d  = class_pos[dbd_pkg::CLS_W-1:0];
    end
    count_d = is_last_o ? '0 : count_q + dbd_pkg::NCLS_W'(1);
  end

  // Threshold check on the updated best score (threshold is non-negative)
  assign emit_o = is_last_o &&
                  ($signed({best_d[dbd_pkg::FEAT_W-1], best_d}) >=
                   $signed({2'b00, conf_threshold_i}));

  assign prop_o.center_x    = cx_d;
  assign prop_o.center_y    = cy_d;
  assign prop_o.box_width   = bw_d;
  assign prop_o.box_height  = bh_d;
  assign prop_o.score       = best_d;
  assign prop_o.class_index = cls_d;

  // Hold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      bw_q    <= '0;
      bh_q    <= '0;
      best_q  <= '0;
      cls_q   <= '0;
    end else if (fire_i) begin
      count_q <= count_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      bw_q    <= bw_d;
      bh_q    <= bh_d;
      best_q  <= best_d;
      cls_q   <= cls_d;
    end
  end

endmodule

@@ rtl/dbd_axis.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbd_axis
// Corner lane for one axis: forms 2c-s and 2c+s, scales by the frame size,
// then truncates and clamps both corners to [0, size-1].
// ----------------------------------------------------------------------------
module dbd_axis (
  input  logic                               clk_i,
  input  dbd_pkg::pipe_ctrl_t                ctrl_i,
  input  logic signed [dbd_pkg::FEAT_W-1:0]  center_i,
  input  logic signed [dbd_pkg::FEAT_W-1:0]  extent_i,
  input  logic        [dbd_pkg::SIZE_W-1:0]  size_i,
  output logic        [dbd_pkg::COORD_W-1:0] low_o,
  output logic        [dbd_pkg::COORD_W-1:0] high_o
);

  logic signed [dbd_pkg::NUM_W-1:0]  c2, s_ext;
  logic signed [dbd_pkg::NUM_W-1:0]  num_lo_q, num_hi_q;
  logic        [dbd_pkg::SIZE_W-1:0] size_s1_q, size_s2_q;
  logic signed [dbd_pkg::PROD_W-1:0] prod_lo_q, prod_hi_q;
  logic signed [dbd_pkg::SIZE_W:0]   size_sgn;
  logic        [dbd_pkg::SIZE_W-1:0] size_max;

  // Stage 1: doubled center minus / plus extent
  assign c2    = {center_i[dbd_pkg::FEAT_W-1], center_i, 1'b0};
  assign s_ext = {{2{extent_i[dbd_pkg::FEAT_W-1]}}, extent_i};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_load) begin
      num_lo_q  <= c2 - s_ext;
      num_hi_q  <= c2 + s_ext;
      size_s1_q <= size_i;
    end
  end

  // Stage 2: scale by frame size
  assign size_sgn = $signed({1'b0, size_s1_q});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_load) begin
      prod_lo_q <= dbd_pkg::PROD_W'(num_lo_q * size_sgn);
      prod_hi_q <= dbd_pkg::PROD_W'(num_hi_q * size_sgn);
      size_s2_q <= size_s1_q;
    end
  end

  // Truncate and clamp; a zero size always gives a zero product
  assign size_max = size_s2_q - dbd_pkg::SIZE_W'(1);

  function automatic logic [dbd_pkg::COORD_W-1:0] clamp(
    input logic signed [dbd_pkg::PROD_W-1:0] prod,
    input logic        [dbd_pkg::SIZE_W-1:0] limit
  );
    logic [dbd_pkg::QUO_W-1:0] quo;
    quo = prod[dbd_pkg::PROD_W-2:dbd_pkg::FRAC_BITS+1];
    if (prod[dbd_pkg::PROD_W-1] || (prod == '0)) begin
      return '0;
    end
    if (quo > dbd_pkg::QUO_W'(limit)) begin
      return limit[dbd_pkg::COORD_W-1:0];
    end
    return quo[dbd_pkg::COORD_W-1:0];
  endfunction

  assign low_o  = clamp(prod_lo_q, size_max);
  assign high_o = clamp(prod_hi_q, size_max);

endmodule

@@ rtl/detection_box_decode_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_box_decode_top
// Anchor-free detector box decode: proposal features in, clamped boxes out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one Q4.12 feature word per
//   cycle: center x, center y, width, height, then num_classes class scores.
//   The last word of a proposal yields at most one box on the output channel
//   (out_valid_o / out_ready_i): corners in pixels, best score and class.
//   Throughput is one word per cycle while in_ready_o is high. A box that
//   passes the threshold loads the difference stage on the edge that accepts
//   its last word, then moves on to the multiply stage and then to the output
//   register, where it is valid on the outputs.
//   The three result stages form an elastic pipeline: when the receiver
//   stalls, boxes back up in it, and in_ready_o drops only for a last word
//   while the first stage is full and cannot drain. Other words keep flowing.
//   Configuration (cfg_valid_i / cfg_ready_o) is always ready; registers are
//   image width, image height, confidence threshold, class count, by index.
//   Reset clears the feature counter, the pipeline and sets the registers to
//   640, 640, 2048 and 10.
// ----------------------------------------------------------------------------
module detection_box_decode_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dbd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [dbd_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // feature input
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [dbd_pkg::FEAT_W-1:0]    feature_value_i,
  // box output
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic        [dbd_pkg::COORD_W-1:0]   left_o,
  output logic        [dbd_pkg::COORD_W-1:0]   top_o,
  output logic        [dbd_pkg::COORD_W-1:0]   right_o,
  output logic        [dbd_pkg::COORD_W-1:0]   bottom_o,
  output logic signed [dbd_pkg::FEAT_W-1:0]    score_o,
  output logic        [dbd_pkg::CLS_W-1:0]     class_index_o
);

  logic [dbd_pkg::SIZE_W-1:0] width_q, height_q;
  logic [dbd_pkg::THR_W-1:0]  thr_q;
  logic [dbd_pkg::NCLS_W-1:0] ncls_q;

  logic                 in_fire, is_last, emit;
  dbd_pkg::prop_t       prop;
  dbd_pkg::pipe_ctrl_t  ctrl;
  logic                 s1_valid_q, s2_valid_q, out_valid_q;
  logic                 s1_free, s2_free, out_free, out_load;
  logic signed [dbd_pkg::FEAT_W-1:0] score_s1_q, score_s2_q, score_q;
  logic        [dbd_pkg::CLS_W-1:0]  cls_s1_q, cls_s2_q, cls_q;
  logic [dbd_pkg::COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;
  logic [dbd_pkg::COORD_W-1:0] left_q, top_q, right_q, bottom_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dbd_pkg::IMAGE_WIDTH_RST;
      height_q <= dbd_pkg::IMAGE_HEIGHT_RST;
      thr_q    <= dbd_pkg::CONF_THRESHOLD_RST;
      ncls_q   <= dbd_pkg::NUM_CLASSES_RST;
    end else if (cfg_valid_i) begin
      unique case (dbd_pkg::cfg_idx_e'(cfg_index_i))
        dbd_pkg::CFG_IMAGE_WIDTH: begin
          width_q <= cfg_data_i[dbd_pkg::SIZE_W-1:0];
        end
        dbd_pkg::CFG_IMAGE_HEIGHT: begin
          height_q <= cfg_data_i[dbd_pkg::SIZE_W-1:0];
        end
        dbd_pkg::CFG_CONF_THRESHOLD: begin
          thr_q <= cfg_data_i[dbd_pkg::THR_W-1:0];
        end
        dbd_pkg::CFG_NUM_CLASSES: begin
          ncls_q <= cfg_data_i[dbd_pkg::NCLS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control
  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_free    = !s2_valid_q || out_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_ready_o = !is_last || s1_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign ctrl.s1_load = in_fire && emit;
  assign ctrl.s2_load = s1_valid_q && s2_free;
  assign out_load     = s2_valid_q && out_free;

  dbd_accum u_accum (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (in_fire),
    .feature_value_i  (feature_value_i),
    .num_classes_i    (ncls_q),
    .conf_threshold_i (thr_q),
    .is_last_o        (is_last),
    .emit_o           (emit),
    .prop_o           (prop)
  );

  dbd_axis u_axis_x (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .center_i (prop.center_x),
    .extent_i (prop.box_width),
    .size_i   (dbd_pkg::eff_size(width_q)),
    .low_o    (x_lo),
    .high_o   (x_hi)
  );

  dbd_axis u_axis_y (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .center_i (prop.center_y),
    .extent_i (prop.box_height),
    .size_i   (dbd_pkg::eff_size(height_q)),
    .low_o    (y_lo),
    .high_o   (y_hi)
  );

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (ctrl.s2_load) begin
        s1_valid_q <= 1'b0;
      end
      if (ctrl.s2_load) begin
        s2_valid_q <= 1'b1;
      end else if (out_load) begin
        s2_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Score and class ride alongside the corner lanes
  always_ff @(posedge clk_i) begin
    if (ctrl.s1_load) begin
      score_s1_q <= prop.score;
      cls_s1_q   <= prop.class_index;
    end
    if (ctrl.s2_load) begin
      score_s2_q <= score_s1_q;
      cls_s2_q   <= cls_s1_q;
    end
    if (out_load) begin
      score_q  <= score_s2_q;
      cls_q    <= cls_s2_q;
      left_q   <= x_lo;
      right_q  <= x_hi;
      top_q    <= y_lo;
      bottom_q <= y_hi;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_o        = left_q;
  assign top_o         = top_q;
  assign right_o       = right_q;
  assign bottom_o      = bottom_q;
  assign score_o       = score_q;
  assign class_index_o = cls_q;

  // A new box never lands on an occupied first stage that cannot drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.s1_load |-> (!s1_valid_q || s2_free))
    else $error("first stage overwritten");

  // A stalled second stage keeps its box
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !out_free) |=> s2_valid_q)
    else $error("second stage box lost under stall");

  // Input back-pressure only comes from a full pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && s2_valid_q && out_valid_q))
    else $error("input stalled with room in the pipeline");

  // Only the scored classes can win
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (cls_q < dbd_pkg::CLS_W'(dbd_pkg::MAX_SCORED_CLASSES)))
    else $error("class index beyond scored classes");

endmodule

@@ test/tb_detection_box_decode_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_detection_box_decode_top
// Self-checking bench for the detection box decoder. A driver streams feature
// words from a queue in random bursts, a monitor tracks every accepted word
// in a local decoder model and checks each box against the oldest predicted
// box. Directed proposals cover field extremes, tie breaks, frame and class
// count clamping and a class count change inside a proposal; random phases
// retune the registers and stream random proposals under receiver stalls.
// ----------------------------------------------------------------------------
module tb_detection_box_decode_top;
  import dbd_pkg::*;

  localparam int IDLE_LIMIT   = 4000;  // cycles with no handshake at all
  localparam int LONG_HOLD    = 400;   // receiver hold-off to fill the pipe
  localparam int SETTLE_TICKS = 8;     // pipeline depth plus margin

  typedef struct packed {
    logic        [COORD_W-1:0] left;
    logic        [COORD_W-1:0] top;
    logic        [COORD_W-1:0] right;
    logic        [COORD_W-1:0] bottom;
    logic signed [FEAT_W-1:0]  score;
    logic        [CLS_W-1:0]   cls;
  } box_t;

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     cfg_valid_i     = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i      = '0;
  logic                     in_valid_i      = 1'b0;
  logic                     in_ready_o;
  logic signed [FEAT_W-1:0] feature_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i     = 1'b0;
  logic [COORD_W-1:0]       left_o, top_o, right_o, bottom_o;
  logic signed [FEAT_W-1:0] score_o;
  logic [CLS_W-1:0]         class_index_o;

  detection_box_decode_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .feature_value_i(feature_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_o         (left_o),
    .top_o          (top_o),
    .right_o        (right_o),
    .bottom_o       (bottom_o),
    .score_o        (score_o),
    .class_index_o  (class_index_o)
  );

  // Local copy of the registers, updated on each accepted config write
  logic [SIZE_W-1:0] img_w_cfg = IMAGE_WIDTH_RST;
  logic [SIZE_W-1:0] img_h_cfg = IMAGE_HEIGHT_RST;
  logic [THR_W-1:0]  thr_cfg   = CONF_THRESHOLD_RST;
  logic [NCLS_W-1:0] ncls_cfg  = NUM_CLASSES_RST;

  // Local copy of the proposal state
  logic [NCLS_W-1:0]        feat_count = '0;
  logic signed [FEAT_W-1:0] cx_hold = '0, cy_hold = '0, bw_hold = '0, bh_hold = '0;
  logic signed [FEAT_W-1:0] best_hold = '0;
  logic [CLS_W-1:0]         best_cls_hold = '0;

  logic signed [FEAT_W-1:0] feature_q[$];   // words waiting to be driven
  box_t                     box_expect_q[$];

  int  feat_pushed = 0;
  int  feat_accepted = 0;
  int  cfg_writes = 0;
  int  fail_count = 0;
  int  idle_cycles = 0;
  logic feat_taken = 1'b0;

  int  burst_left = 0, gap_left = 0;
  int  stall_mode = 0, stall_window = 0, hold_left = 0, pace_tick = 0;
  bit  long_hold_wanted = 1'b0, long_hold_done = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------

  // Effective class count after clamping
  function automatic int class_span();
    int n;
    n = ncls_cfg;
    if (n == 0) n = 1;
    if (n > CLASS_LIMIT) n = CLASS_LIMIT;
    return n;
  endfunction

  function automatic logic [SIZE_W-1:0] frame_limit(input logic [SIZE_W-1:0] size);
    return (size > SIZE_W'(MAX_IMAGE_SIZE)) ? SIZE_W'(MAX_IMAGE_SIZE) : size;
  endfunction

  // (2c -/+ s) * size / 2^(FRAC_BITS+1), floored, clamped to [0, size-1]
  function automatic logic [COORD_W-1:0] corner_px(input logic signed [FEAT_W-1:0] c,
                                                   input logic signed [FEAT_W-1:0] s,
                                                   input logic minus,
                                                   input logic [SIZE_W-1:0] size);
    longint sz, num, q;
    sz = size;
    if (sz == 0) return '0;
    num = 2 * longint'(c) + (minus ? -longint'(s) : longint'(s));
    num = num * sz;
    if (num <= 0) return '0;
    q = num >>> (FRAC_BITS + 1);
    if (q > sz - 1) q = sz - 1;
    return q[COORD_W-1:0];
  endfunction

  task automatic decode_feature(input logic signed [FEAT_W-1:0] v);
    int   k, last, c;
    box_t b;
    logic [SIZE_W-1:0] w, h;
    k    = feat_count;
    last = BOX_FEATURES - 1 + class_span();
    case (k)
      0: cx_hold = v;
      1: cy_hold = v;
      2: bw_hold = v;
      3: bh_hold = v;
      default: begin
        c = k - BOX_FEATURES;
        if (c == 0) begin
          best_hold     = v;
          best_cls_hold = '0;
        end else if (c < MAX_SCORED_CLASSES && v > best_hold) begin
          best_hold     = v;
          best_cls_hold = CLS_W'(c);
        end
      end
    endcase
    if (k < last) begin
      feat_count = NCLS_W'(k + 1);
      return;
    end
    // last word of the proposal (also when a shrunk class count overtook k)
    feat_count = '0;
    if (int'(best_hold) < int'(thr_cfg)) return;
    w        = frame_limit(img_w_cfg);
    h        = frame_limit(img_h_cfg);
    b.left   = corner_px(cx_hold, bw_hold, 1'b1, w);
    b.top    = corner_px(cy_hold, bh_hold, 1'b1, h);
    b.right  = corner_px(cx_hold, bw_hold, 1'b0, w);
    b.bottom = corner_px(cy_hold, bh_hold, 1'b0, h);
    b.score  = best_hold;
    b.cls    = best_cls_hold;
    box_expect_q = {box_expect_q, b};
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: config, input and output handshakes, plus the watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : box_monitor
    box_t b;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (box_expect_q.size() == 0) begin
          $error("box with none expected: left %0d top %0d right %0d bottom %0d",
                 left_o, top_o, right_o, bottom_o);
          fail_count++;
        end else begin
          b = box_expect_q.pop_front();
          check_field("left", b.left, left_o);
          check_field("top", b.top, top_o);
          check_field("right", b.right, right_o);
          check_field("bottom", b.bottom, bottom_o);
          check_field("score", int'(b.score), int'(score_o));
          check_field("class_index", b.cls, class_index_o);
        end
      end

      if (in_valid_i && in_ready_o) begin
        decode_feature(feature_value_i);
        feat_accepted++;
      end
      feat_taken <= in_valid_i && in_ready_o;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_IMAGE_WIDTH:    img_w_cfg = cfg_data_i[SIZE_W-1:0];
          CFG_IMAGE_HEIGHT:   img_h_cfg = cfg_data_i[SIZE_W-1:0];
          CFG_CONF_THRESHOLD: thr_cfg   = cfg_data_i[THR_W-1:0];
          CFG_NUM_CLASSES:    ncls_cfg  = cfg_data_i[NCLS_W-1:0];
          default: ;
        endcase
        cfg_writes++;
      end

      // watchdog on handshake activity
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: feature words in bursts with random gaps
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : feature_driver
    logic                     nv;
    logic signed [FEAT_W-1:0] nd;
    nv = in_valid_i;
    nd = feature_value_i;
    if (!in_valid_i || feat_taken) begin
      nv = 1'b0;
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 16);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end
      if (burst_left > 0) begin
        if (feature_q.size() > 0) begin
          nv = 1'b1;
          nd = feature_q.pop_front();
          burst_left--;
        end
      end else begin
        gap_left--;
      end
    end
    in_valid_i      <= nv;
    feature_value_i <= nd;
  end

  // --------------------------------------------------------------------------
  // Receiver pacing: stall modes in random windows, one long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : box_sink_pacer
    logic nr;
    if (long_hold_wanted && !long_hold_done) begin
      hold_left      = LONG_HOLD;
      long_hold_done = 1'b1;
    end
    if (stall_window == 0) begin
      stall_mode   = $urandom_range(0, 3);
      stall_window = $urandom_range(16, 96);
    end
    stall_window--;
    pace_tick++;
    if (hold_left > 0) begin
      nr = 1'b0;
      hold_left--;
    end else begin
      case (stall_mode)
        0:       nr = 1'b1;
        1:       nr = ($urandom_range(0, 3) != 0);
        2:       nr = ($urandom_range(0, 3) == 0);
        default: nr = ((pace_tick % 3) == 0);
      endcase
    end
    out_ready_i <= nr;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_word(input logic signed [FEAT_W-1:0] v);
    feature_q = {feature_q, v};
    feat_pushed++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    int seen;
    seen = cfg_writes;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    while (cfg_writes == seen) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic setup(input int w, input int h, input int thr, input int ncls);
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_CONF_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_NUM_CLASSES, CFG_DATA_W'(ncls));
  endtask

  // Wait until every word is taken and every box is out, then let the pipe settle
  task automatic wait_idle();
    while (feat_accepted != feat_pushed || box_expect_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  task automatic push_proposal(input int cx, input int cy, input int bw, input int bh,
                               input int sc);
    push_word(FEAT_W'(cx));
    push_word(FEAT_W'(cy));
    push_word(FEAT_W'(bw));
    push_word(FEAT_W'(bh));
    push_word(FEAT_W'(sc));
  endtask

  // Random proposal for the current class count, optionally cut off early
  task automatic queue_random_proposal(input bit cut_short);
    int total, kind, r;
    logic signed [FEAT_W-1:0] prev, v;
    total = BOX_FEATURES + class_span();
    if (cut_short) total = $urandom_range(1, total - 1);
    kind = $urandom_range(0, 3);
    prev = '0;
    for (int i = 0; i < total; i++) begin
      if (i < BOX_FEATURES) begin
        case (kind)
          0: v = FEAT_W'($urandom);
          1: v = FEAT_W'($urandom_range(0, 4096));
          2: v = (i < 2) ? FEAT_W'(($urandom_range(0, 1)) ? $urandom_range(0, 256)
                                                          : $urandom_range(3840, 4096))
                         : FEAT_W'($urandom_range(2048, 8192));
          default: v = FEAT_W'(int'($urandom_range(0, 1024)) - 512);
        endcase
      end else begin
        r = $urandom_range(0, 7);
        case (r)
          0, 1:    v = FEAT_W'($urandom);
          2:       v = prev;  // tie with the previous class
          3:       v = FEAT_W'(int'(thr_cfg) + int'($urandom_range(0, 2)) - 1);
          default: v = FEAT_W'($urandom_range(0, 8191));
        endcase
      end
      prev = v;
      push_word(v);
    end
  endtask

  // Random register settings, each register rewritten with some probability
  task automatic retune_random();
    int w, h, t, n;
    w = $urandom_range(0, 15);
    w = (w == 0) ? 1 : (w == 1) ? MAX_IMAGE_SIZE : (w == 2) ? 0 :
        (w == 3) ? $urandom_range(MAX_IMAGE_SIZE + 1, 8191) : $urandom_range(2, 4095);
    h = $urandom_range(0, 15);
    h = (h == 0) ? 1 : (h == 1) ? MAX_IMAGE_SIZE : (h == 2) ? 0 :
        (h == 3) ? $urandom_range(MAX_IMAGE_SIZE + 1, 8191) : $urandom_range(2, 4095);
    t = $urandom_range(0, 19);
    t = (t == 0) ? 0 : (t < 3) ? $urandom_range(0, 32767) : $urandom_range(0, 4096);
    n = $urandom_range(0, 39);
    n = (n == 0) ? 0 : (n == 1) ? CLASS_LIMIT : (n == 2) ? $urandom_range(81, 127) :
        (n < 8) ? $urandom_range(7, 16) : $urandom_range(1, 6);
    // upper data bits are random: the block must ignore them
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_IMAGE_WIDTH, {3'($urandom), SIZE_W'(w)});
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_IMAGE_HEIGHT, {3'($urandom), SIZE_W'(h)});
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_CONF_THRESHOLD, {1'($urandom), THR_W'(t)});
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_NUM_CLASSES, {9'($urandom), NCLS_W'(n)});
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : test_sequence
    int random_start, phase_start, target, phases;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: class 9 beats a tie pair, then all scores at threshold
    push_word(FEAT_W'(2048));
    push_word(FEAT_W'(2048));
    push_word(FEAT_W'(1024));
    push_word(FEAT_W'(2048));
    push_word(FEAT_W'(100));
    push_word(FEAT_W'(3000));
    push_word(FEAT_W'(3000));
    push_word(FEAT_W'(2047));
    push_word(FEAT_W'(-32768));
    push_word(FEAT_W'(0));
    push_word(FEAT_W'(1));
    push_word(FEAT_W'(2999));
    push_word(FEAT_W'(3000));
    push_word(FEAT_W'(3001));
    for (int i = 0; i < BOX_FEATURES; i++) push_word(FEAT_W'(1000));
    for (int i = 0; i < 10; i++) push_word(FEAT_W'(2048));
    wait_idle();

    // One class, zero threshold: field extremes
    setup(640, 480, 0, 1);
    push_proposal(32767, 32767, 32767, 32767, 32767);
    push_proposal(-32768, -32768, -32768, -32768, -32768);  // negative score dropped
    push_proposal(0, 0, 0, 0, 0);
    push_proposal(-32768, 32767, 32767, -32768, 0);
    wait_idle();

    // Unit width, oversized height, top threshold, zero class count
    setup(1, 8191, 32767, 0);
    push_proposal(2048, 2048, 4096, 4096, 32767);
    push_proposal(2048, 2048, 4096, 4096, 32766);           // just under threshold
    wait_idle();

    // Zero-size width, full height, oversized class count: class 12 is not scored
    setup(0, MAX_IMAGE_SIZE, 0, 127);
    push_word(FEAT_W'(2048));
    push_word(FEAT_W'(1024));
    push_word(FEAT_W'(4096));
    push_word(FEAT_W'(1024));
    for (int c = 0; c < CLASS_LIMIT; c++)
      push_word(FEAT_W'((c == 0) ? 10 : (c == 5) ? 20 : (c == 12) ? 32767 : 0));
    wait_idle();

    // Class count shrunk inside a proposal: the next word closes it
    setup(MAX_IMAGE_SIZE, MAX_IMAGE_SIZE, 0, 10);
    for (int i = 0; i < BOX_FEATURES + 7; i++) push_word(FEAT_W'(500 + i));
    wait_idle();
    write_reg(CFG_NUM_CLASSES, CFG_DATA_W'(3));
    push_word(FEAT_W'(700));
    wait_idle();

    // Back-pressure: short proposals while the receiver holds off
    setup(640, 640, 0, 1);
    long_hold_wanted = 1'b1;
    for (int i = 0; i < 30; i++) queue_random_proposal(1'b0);
    wait_idle();

    // Random phases
    random_start = feat_pushed;
    phases = 0;
    while (feat_pushed - random_start < 500 && phases < 200) begin
      retune_random();
      target      = $urandom_range(40, 120);
      phase_start = feat_pushed;
      while (feat_pushed - phase_start < target) queue_random_proposal(1'b0);
      if ($urandom_range(0, 4) == 0) queue_random_proposal(1'b1);
      wait_idle();
      phases++;
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/dbd_pkg.sv
rtl/dbd_accum.sv
rtl/dbd_axis.sv
rtl/detection_box_decode_top.sv
test/tb_detection_box_decode_top.sv
